// ----- rtl/ssd_pkg.sv -----
// Shared constants and types for the segment-to-segment distance pipeline.
// Used by every module of the block; depends on nothing.
package ssd_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 8;
    localparam int DIST_BITS     = 25;
    localparam int UNITS         = 4;

    // Derived arithmetic widths.
    localparam int DIFW   = COORD_BITS + 1;
    localparam int PRODW  = 2 * DIFW;
    localparam int SUMW   = PRODW + 1;
    localparam int NW     = 2 * COORD_BITS + 1;
    localparam int HALFW  = (NW + 1) / 2;
    localparam int HIW    = NW - HALFW;
    localparam int LOW2   = 2 * HALFW;
    localparam int HI2    = 2 * HIW;
    localparam int NUMSQW = 2 * NW;
    localparam int NUMW   = NUMSQW + 2 * FRACTION_BITS + 2;
    localparam int QW     = NW + 2 * FRACTION_BITS + 2;
    localparam int SQW    = (QW + 1) / 2;
    localparam int RADW   = 2 * SQW;
    localparam int REMW   = SQW + 2;
    localparam int CORE_LAT = QW + SQW;

    localparam int IN_TDATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DIST_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [DIST_BITS-1:0] t_dist;

    localparam t_dist DIST_MAX = '1;

    // One squared distance as a fraction num/den, and whether num is zero.
    typedef struct packed {
        logic [NUMSQW-1:0] num;
        logic [NW-1:0]     den;
        logic              hit;
    } t_unit;

endpackage

// ----- rtl/ssd_front.sv -----
// Front end: differences, products, case selection and the crossing test.
// Produces four squared-distance fractions per item. Depends on ssd_pkg.
module ssd_front import ssd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_coord i_ax,
    input  t_coord i_ay,
    input  t_coord i_bx,
    input  t_coord i_by,
    input  t_coord i_cx,
    input  t_coord i_cy,
    input  t_coord i_dx,
    input  t_coord i_dy,
    output logic   o_valid,
    output logic   o_cross_touch,
    output t_unit  o_unit [0:UNITS-1]
);

    // Point and segment of each unit: A and B against CD, C and D against AB.
    t_coord w_px [0:UNITS-1];
    t_coord w_py [0:UNITS-1];
    t_coord w_sax [0:UNITS-1];
    t_coord w_say [0:UNITS-1];
    t_coord w_sbx [0:UNITS-1];
    t_coord w_sby [0:UNITS-1];

    always_comb begin
        w_px[0] = i_ax; w_py[0] = i_ay;
        w_px[1] = i_bx; w_py[1] = i_by;
        w_px[2] = i_cx; w_py[2] = i_cy;
        w_px[3] = i_dx; w_py[3] = i_dy;
        w_sax[0] = i_cx; w_say[0] = i_cy; w_sbx[0] = i_dx; w_sby[0] = i_dy;
        w_sax[1] = i_cx; w_say[1] = i_cy; w_sbx[1] = i_dx; w_sby[1] = i_dy;
        w_sax[2] = i_ax; w_say[2] = i_ay; w_sbx[2] = i_bx; w_sby[2] = i_by;
        w_sax[3] = i_ax; w_say[3] = i_ay; w_sbx[3] = i_bx; w_sby[3] = i_by;
    end

    // Stage 1: coordinate differences.
    logic signed [DIFW-1:0] r1_sx [0:UNITS-1];
    logic signed [DIFW-1:0] r1_sy [0:UNITS-1];
    logic signed [DIFW-1:0] r1_apx [0:UNITS-1];
    logic signed [DIFW-1:0] r1_apy [0:UNITS-1];
    logic signed [DIFW-1:0] r1_qx [0:UNITS-1];
    logic signed [DIFW-1:0] r1_qy [0:UNITS-1];
    logic signed [DIFW-1:0] r1_abx, r1_aby, r1_acx, r1_acy, r1_cdx, r1_cdy;
    logic r1_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < UNITS; u++) begin
                r1_sx[u]  <= DIFW'(w_sbx[u]) - DIFW'(w_sax[u]);
                r1_sy[u]  <= DIFW'(w_sby[u]) - DIFW'(w_say[u]);
                r1_apx[u] <= DIFW'(w_px[u]) - DIFW'(w_sax[u]);
                r1_apy[u] <= DIFW'(w_py[u]) - DIFW'(w_say[u]);
                r1_qx[u]  <= DIFW'(w_px[u]) - DIFW'(w_sbx[u]);
                r1_qy[u]  <= DIFW'(w_py[u]) - DIFW'(w_sby[u]);
            end
            r1_abx <= DIFW'(i_bx) - DIFW'(i_ax);
            r1_aby <= DIFW'(i_by) - DIFW'(i_ay);
            r1_acx <= DIFW'(i_cx) - DIFW'(i_ax);
            r1_acy <= DIFW'(i_cy) - DIFW'(i_ay);
            r1_cdx <= DIFW'(i_dx) - DIFW'(i_cx);
            r1_cdy <= DIFW'(i_dy) - DIFW'(i_cy);
        end
    end

    // Stage 2: products.
    logic signed [PRODW-1:0] r2_sxx [0:UNITS-1];
    logic signed [PRODW-1:0] r2_syy [0:UNITS-1];
    logic signed [PRODW-1:0] r2_sxa [0:UNITS-1];
    logic signed [PRODW-1:0] r2_sya [0:UNITS-1];
    logic signed [PRODW-1:0] r2_sxay [0:UNITS-1];
    logic signed [PRODW-1:0] r2_syax [0:UNITS-1];
    logic signed [PRODW-1:0] r2_axx [0:UNITS-1];
    logic signed [PRODW-1:0] r2_ayy [0:UNITS-1];
    logic signed [PRODW-1:0] r2_qxx [0:UNITS-1];
    logic signed [PRODW-1:0] r2_qyy [0:UNITS-1];
    logic signed [PRODW-1:0] r2_k1a, r2_k1b, r2_k2a, r2_k2b, r2_kea, r2_keb;
    logic r2_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < UNITS; u++) begin
                r2_sxx[u]  <= PRODW'(r1_sx[u]) * PRODW'(r1_sx[u]);
                r2_syy[u]  <= PRODW'(r1_sy[u]) * PRODW'(r1_sy[u]);
                r2_sxa[u]  <= PRODW'(r1_sx[u]) * PRODW'(r1_apx[u]);
                r2_sya[u]  <= PRODW'(r1_sy[u]) * PRODW'(r1_apy[u]);
                r2_sxay[u] <= PRODW'(r1_sx[u]) * PRODW'(r1_apy[u]);
                r2_syax[u] <= PRODW'(r1_sy[u]) * PRODW'(r1_apx[u]);
                r2_axx[u]  <= PRODW'(r1_apx[u]) * PRODW'(r1_apx[u]);
                r2_ayy[u]  <= PRODW'(r1_apy[u]) * PRODW'(r1_apy[u]);
                r2_qxx[u]  <= PRODW'(r1_qx[u]) * PRODW'(r1_qx[u]);
                r2_qyy[u]  <= PRODW'(r1_qy[u]) * PRODW'(r1_qy[u]);
            end
            r2_k1a <= PRODW'(r1_abx) * PRODW'(r1_cdy);
            r2_k1b <= PRODW'(r1_aby) * PRODW'(r1_cdx);
            r2_k2a <= PRODW'(r1_acx) * PRODW'(r1_aby);
            r2_k2b <= PRODW'(r1_acy) * PRODW'(r1_abx);
            r2_kea <= PRODW'(r1_acx) * PRODW'(r1_cdy);
            r2_keb <= PRODW'(r1_acy) * PRODW'(r1_cdx);
        end
    end

    // Stage 3: sums of products.
    logic signed [SUMW-1:0] r3_n [0:UNITS-1];
    logic signed [SUMW-1:0] r3_d [0:UNITS-1];
    logic signed [SUMW-1:0] r3_cr [0:UNITS-1];
    logic signed [SUMW-1:0] r3_dp [0:UNITS-1];
    logic signed [SUMW-1:0] r3_dq [0:UNITS-1];
    logic signed [SUMW-1:0] r3_c1, r3_c2, r3_e;
    logic r3_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < UNITS; u++) begin
                r3_n[u]  <= SUMW'(r2_sxx[u]) + SUMW'(r2_syy[u]);
                r3_d[u]  <= SUMW'(r2_sxa[u]) + SUMW'(r2_sya[u]);
                r3_cr[u] <= SUMW'(r2_sxay[u]) - SUMW'(r2_syax[u]);
                r3_dp[u] <= SUMW'(r2_axx[u]) + SUMW'(r2_ayy[u]);
                r3_dq[u] <= SUMW'(r2_qxx[u]) + SUMW'(r2_qyy[u]);
            end
            r3_c1 <= SUMW'(r2_k1a) - SUMW'(r2_k1b);
            r3_c2 <= SUMW'(r2_k2a) - SUMW'(r2_k2b);
            r3_e  <= SUMW'(r2_kea) - SUMW'(r2_keb);
        end
    end

    // Stage 4: pick the nearest feature of each segment, and test for crossing.
    logic signed [SUMW-1:0] w_abs [0:UNITS-1];
    logic [NW-1:0] w_sel [0:UNITS-1];
    logic          w_perp [0:UNITS-1];
    logic          w_col, w_pos, w_neg;

    always_comb begin
        for (int u = 0; u < UNITS; u++) begin
            w_abs[u] = r3_cr[u][SUMW-1] ? -r3_cr[u] : r3_cr[u];
            if (r3_n[u] == 0 || r3_d[u] <= 0) begin
                w_perp[u] = 1'b0;
                w_sel[u]  = r3_dp[u][NW-1:0];
            end else if (r3_d[u] >= r3_n[u]) begin
                w_perp[u] = 1'b0;
                w_sel[u]  = r3_dq[u][NW-1:0];
            end else begin
                w_perp[u] = 1'b1;
                w_sel[u]  = w_abs[u][NW-1:0];
            end
        end
        // Collinear overlap: projections of C and D onto AB meet [0, |AB|^2].
        w_col = (r3_c1 == 0) && (r3_c2 == 0) && (r3_n[2] != 0)
             && (r3_d[2] <= r3_n[2] || r3_d[3] <= r3_n[2])
             && (r3_d[2] >= 0 || r3_d[3] >= 0);
        // Proper crossing: both line parameters in [0, 1], by sign of c1.
        w_pos = (r3_c1 > 0) && (r3_e >= 0) && (r3_e <= r3_c1)
             && (r3_c2 >= 0) && (r3_c2 <= r3_c1);
        w_neg = (r3_c1 < 0) && (r3_e <= 0) && (r3_e >= r3_c1)
             && (r3_c2 <= 0) && (r3_c2 >= r3_c1);
    end

    logic [NW-1:0] r4_mag [0:UNITS-1];
    logic [NW-1:0] r4_den [0:UNITS-1];
    logic          r4_perp [0:UNITS-1];
    logic          r4_hit [0:UNITS-1];
    logic          r4_ct;
    logic          r4_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < UNITS; u++) begin
                r4_mag[u]  <= w_sel[u];
                r4_perp[u] <= w_perp[u];
                r4_den[u]  <= w_perp[u] ? r3_n[u][NW-1:0] : NW'(1);
                r4_hit[u]  <= (w_sel[u] == '0);
            end
            r4_ct <= w_col | w_pos | w_neg;
        end
    end

    // Stage 5: partial products of the cross product's square.
    logic [HI2-1:0]  r5_ph [0:UNITS-1];
    logic [NW-1:0]   r5_pm [0:UNITS-1];
    logic [LOW2-1:0] r5_pl [0:UNITS-1];
    logic [NW-1:0]   r5_val [0:UNITS-1];
    logic [NW-1:0]   r5_den [0:UNITS-1];
    logic            r5_perp [0:UNITS-1];
    logic            r5_hit [0:UNITS-1];
    logic            r5_ct;
    logic            r5_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < UNITS; u++) begin
                r5_ph[u]   <= HI2'(r4_mag[u][NW-1:HALFW]) * HI2'(r4_mag[u][NW-1:HALFW]);
                r5_pm[u]   <= NW'(r4_mag[u][NW-1:HALFW]) * NW'(r4_mag[u][HALFW-1:0]);
                r5_pl[u]   <= LOW2'(r4_mag[u][HALFW-1:0]) * LOW2'(r4_mag[u][HALFW-1:0]);
                r5_val[u]  <= r4_mag[u];
                r5_den[u]  <= r4_den[u];
                r5_perp[u] <= r4_perp[u];
                r5_hit[u]  <= r4_hit[u];
            end
            r5_ct <= r4_ct;
        end
    end

    // Stage 6: assemble the numerator.
    t_unit r6_unit [0:UNITS-1];
    logic  r6_ct;
    logic  r6_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < UNITS; u++) begin
                r6_unit[u].num <= r5_perp[u]
                    ? (NUMSQW'(r5_ph[u]) << LOW2) + (NUMSQW'(r5_pm[u]) << (HALFW + 1))
                      + NUMSQW'(r5_pl[u])
                    : NUMSQW'(r5_val[u]);
                r6_unit[u].den <= r5_den[u];
                r6_unit[u].hit <= r5_hit[u];
            end
            r6_ct <= r5_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    assign o_valid       = r6_v;
    assign o_cross_touch = r6_ct;
    assign o_unit        = r6_unit;

endmodule

// ----- rtl/ssd_div.sv -----
// Pipelined restoring divider: floor(num * 2^(2F+2) / den), one quotient bit per stage.
// The quotient is known to fit in QW bits. Depends on ssd_pkg.
module ssd_div import ssd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  t_unit         i_unit,
    output logic [QW-1:0] o_quo,
    output logic          o_hit
);

    logic [NUMW-1:0] w_numer;
    assign w_numer = {i_unit.num, {(NUMW - NUMSQW){1'b0}}};

    logic [NW-1:0] r_rem [0:QW-1];
    logic [NW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];
    logic          r_hit [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [NW-1:0] w_rem_in, w_den_in;
        logic [QW-1:0] w_low_in, w_quo_in;
        logic          w_hit_in, w_ge;
        logic [NW:0]   w_sh, w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in = w_numer[NUMW-1:QW];
            assign w_low_in = w_numer[QW-1:0];
            assign w_quo_in = '0;
            assign w_den_in = i_unit.den;
            assign w_hit_in = i_unit.hit;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
            assign w_hit_in = r_hit[k-1];
        end

        assign w_sh   = {w_rem_in, w_low_in[QW-1]};
        assign w_ge   = (w_sh >= {1'b0, w_den_in});
        assign w_diff = w_sh - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[NW-1:0] : w_sh[NW-1:0];
                r_low[k] <= {w_low_in[QW-2:0], 1'b0};
                r_quo[k] <= {w_quo_in[QW-2:0], w_ge};
                r_den[k] <= w_den_in;
                r_hit[k] <= w_hit_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_hit = r_hit[QW-1];

endmodule

// ----- rtl/ssd_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives floor(sqrt(radicand)). Depends on ssd_pkg.
module ssd_sqrt import ssd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [QW-1:0]  i_rad,
    input  logic           i_hit,
    output logic [SQW-1:0] o_root,
    output logic           o_hit
);

    logic [REMW-1:0] r_rem [0:SQW-1];
    logic [RADW-1:0] r_low [0:SQW-1];
    logic [SQW-1:0]  r_root [0:SQW-1];
    logic            r_hit [0:SQW-1];

    for (genvar k = 0; k < SQW; k++) begin : g_step
        logic [REMW-1:0] w_rem_in;
        logic [RADW-1:0] w_low_in;
        logic [SQW-1:0]  w_root_in;
        logic            w_hit_in, w_ge;
        logic [REMW+1:0] w_sh, w_trial, w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_low_in  = RADW'(i_rad);
            assign w_root_in = '0;
            assign w_hit_in  = i_hit;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_low_in  = r_low[k-1];
            assign w_root_in = r_root[k-1];
            assign w_hit_in  = r_hit[k-1];
        end

        assign w_sh    = {w_rem_in, w_low_in[RADW-1:RADW-2]};
        assign w_trial = (REMW + 2)'({w_root_in, 2'b01});
        assign w_ge    = (w_sh >= w_trial);
        assign w_diff  = w_sh - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[REMW-1:0] : w_sh[REMW-1:0];
                r_low[k]  <= {w_low_in[RADW-3:0], 2'b00};
                r_root[k] <= {w_root_in[SQW-2:0], w_ge};
                r_hit[k]  <= w_hit_in;
            end
        end
    end

    assign o_root = r_root[SQW-1];
    assign o_hit  = r_hit[SQW-1];

endmodule

// ----- rtl/segment_segment_distance_unit.sv -----
// Top level of the segment-to-segment distance pipeline: front end, four divider
// and square-root lanes, rounding, minimum and the output skid stage.
// Depends on ssd_pkg, ssd_front, ssd_div and ssd_sqrt.
//
// Channel     | Direction | Ports            | Payload
// ------------+-----------+------------------+------------------------------------------
// segment in  | input     | i_s_axis_*       | tdata: A.x, A.y, B.x, B.y, C.x, C.y, D.x, D.y
// distance out| output    | o_m_axis_*       | tdata: distance; tuser: touching
//
// The block takes one segment pair per clock while o_s_axis_tready is high and returns one
// result per pair, in order. Between input and output lie 6 front-end stages, 51 divider
// stages (one quotient bit each), 26 square-root stages (one root bit each), 2 stages of
// rounding and minimum, and the output register.
// Reset is synchronous and active low; it clears only the valid bits, there is no
// clearing pass. All stages advance together while the skid register is empty; a stalled
// output parks one result in the skid register and holds the pipeline until it drains.
module segment_segment_distance_unit import ssd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // A.x, A.y, B.x, B.y, C.x, C.y, D.x, D.y from the lowest bit up, 16 bits each
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // distance (25 bits, 8 fraction bits) in the lowest bits, zero filled above
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // touching
    output logic                   o_m_axis_tuser
);

    // Global advance: every pipeline register moves when the skid register is free.
    logic w_en;

    logic  f_valid, f_ct;
    t_unit f_unit [0:UNITS-1];

    ssd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_s_axis_tvalid),
        .i_ax          (i_s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_ay          (i_s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_bx          (i_s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_by          (i_s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .i_cx          (i_s_axis_tdata[4*COORD_BITS +: COORD_BITS]),
        .i_cy          (i_s_axis_tdata[5*COORD_BITS +: COORD_BITS]),
        .i_dx          (i_s_axis_tdata[6*COORD_BITS +: COORD_BITS]),
        .i_dy          (i_s_axis_tdata[7*COORD_BITS +: COORD_BITS]),
        .o_valid       (f_valid),
        .o_cross_touch (f_ct),
        .o_unit        (f_unit)
    );

    // Each lane turns num/den into round(sqrt(num/den) * 2^F): the root of
    // floor(num * 2^(2F+2) / den) is twice the scaled distance, and halving it
    // with the low bit added back rounds to nearest with ties up.
    logic [SQW-1:0] w_root [0:UNITS-1];
    logic           w_hit [0:UNITS-1];

    for (genvar u = 0; u < UNITS; u++) begin : g_lane
        logic [QW-1:0] w_quo;
        logic          w_dhit;

        ssd_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_unit (f_unit[u]),
            .o_quo  (w_quo),
            .o_hit  (w_dhit)
        );

        ssd_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_quo),
            .i_hit  (w_dhit),
            .o_root (w_root[u]),
            .o_hit  (w_hit[u])
        );
    end

    // Valid bits and the crossing flag ride alongside the divider and root lanes.
    logic r_dv [0:CORE_LAT-1];
    logic r_dt [0:CORE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORE_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv[0] <= f_valid;
            for (int k = 1; k < CORE_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dt[0] <= f_ct;
            for (int k = 1; k < CORE_LAT; k++) begin
                r_dt[k] <= r_dt[k-1];
            end
        end
    end

    // Rounding and saturation of each lane.
    logic [SQW-1:0] w_mid [0:UNITS-1];
    t_dist          w_dist [0:UNITS-1];

    always_comb begin
        for (int u = 0; u < UNITS; u++) begin
            w_mid[u]  = SQW'(w_root[u] >> 1) + SQW'(w_root[u][0]);
            w_dist[u] = (w_mid[u] > SQW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(w_mid[u]);
        end
    end

    t_dist r_p1_dist [0:UNITS-1];
    logic  r_p1_t;
    logic  r_p1_v;
    t_dist r_p2_m01, r_p2_m23;
    logic  r_p2_t;
    logic  r_p2_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_dist <= w_dist;
            r_p1_t    <= r_dt[CORE_LAT-1] | w_hit[0] | w_hit[1] | w_hit[2] | w_hit[3];
            r_p2_m01  <= (r_p1_dist[1] < r_p1_dist[0]) ? r_p1_dist[1] : r_p1_dist[0];
            r_p2_m23  <= (r_p1_dist[3] < r_p1_dist[2]) ? r_p1_dist[3] : r_p1_dist[2];
            r_p2_t    <= r_p1_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= r_dv[CORE_LAT-1];
            r_p2_v <= r_p1_v;
        end
    end

    // A touch forces the distance to zero.
    t_dist w_res_dist;
    logic  w_push, w_take;

    assign w_res_dist = r_p2_t ? '0 : ((r_p2_m23 < r_p2_m01) ? r_p2_m23 : r_p2_m01);

    // Output register with a one-entry skid register behind it.
    logic  r_out_v, r_out_touch, r_skid_v, r_skid_touch;
    t_dist r_out_dist, r_skid_dist;

    assign w_en   = !r_skid_v;
    assign w_push = w_en & r_p2_v;
    assign w_take = r_out_v & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_v && !w_take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_dist  <= r_skid_dist;
                r_out_touch <= r_skid_touch;
            end
        end else if (w_push) begin
            if (r_out_v && !w_take) begin
                r_skid_dist  <= w_res_dist;
                r_skid_touch <= r_p2_t;
            end else begin
                r_out_dist  <= w_res_dist;
                r_out_touch <= r_p2_t;
            end
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_dist);
    assign o_m_axis_tuser  = r_out_touch;

    // The skid register only ever holds a result behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    // The skid register fills only after an output transfer was refused.
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_axis_tready))
        else $error("skid register filled without a refused output");

    // A touching result always reports zero distance.
    a_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_touch) |-> (r_out_dist == '0))
        else $error("touching result with nonzero distance");

    // A parked result is kept until the output side takes a transfer.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_axis_tready) |=> (r_skid_v && r_out_v))
        else $error("parked result lost during stall");

endmodule
